### rtl/core/red_pkg.sv
package red_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int CLASS_W     = 2;
	localparam int LEN_W       = 16;
	localparam int AVG_W       = 32;
	localparam int WEIGHT_W    = 17;
	localparam int CFG_W       = 64;
	localparam int LANE_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int REASON_W    = 2;

	localparam int OP_W        = 34;
	localparam int ACC_W       = 51;
	localparam int MUL_STEPS   = 17;
	localparam int CNT_W       = $clog2(MUL_STEPS + 1);

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

	localparam logic [CFG_IDX_W-1:0] REG_AVG_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_THRESH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_THRESH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PROB   = 2'd3;

	localparam logic [WEIGHT_W-1:0] RST_AVG_WEIGHT = WEIGHT_W'(131);
	localparam logic [CFG_W-1:0]    RST_MIN_THRESH = 64'h0005_0005_0005_0005;
	localparam logic [CFG_W-1:0]    RST_MAX_THRESH = 64'h0032_0032_0032_0032;
	localparam logic [CFG_W-1:0]    RST_MAX_PROB   = 64'h051F_051F_051F_051F;

	localparam logic [REASON_W-1:0] REASON_ACCEPT  = 2'd0;
	localparam logic [REASON_W-1:0] REASON_EARLY   = 2'd1;
	localparam logic [REASON_W-1:0] REASON_AVG_MAX = 2'd2;
	localparam logic [REASON_W-1:0] REASON_LEN_MAX = 2'd3;

	typedef logic [OP_W-1:0]  op_t;
	typedef logic [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic bit_a;
		logic bit_b;
	} smac_ctl_t;

endpackage

### rtl/core/red_smac.sv
module red_smac (
	input  logic             clk,
	input  red_pkg::smac_ctl_t ctl,
	input  red_pkg::op_t     op_a,
	input  red_pkg::op_t     op_b,
	input  red_pkg::op_t     op_ab,
	output red_pkg::acc_t    acc
);
	import red_pkg::*;

	op_t  sel;
	acc_t sel_ext;
	acc_t acc_q;

	always_comb begin
		unique case ({ctl.bit_a, ctl.bit_b})
			2'b11:   sel = op_ab;
			2'b10:   sel = op_a;
			2'b01:   sel = op_b;
			default: sel = '0;
		endcase
		sel_ext = {{(ACC_W - OP_W){sel[OP_W-1]}}, sel};
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			acc_q <= {acc_q[ACC_W-2:0], 1'b0} + sel_ext;
		end
	end

	assign acc = acc_q;

endmodule

### rtl/core/red_early_drop_decider.sv
// Random early detection drop decider.
// Requests arrive on the in_valid/in_ready channel with a class, the
// instantaneous queue length and a random number; each request yields one
// result (drop, drop_reason, average_length) on the out_valid/out_ready
// channel. Thresholds and the averaging weight are written through the
// cfg_write/cfg_index/cfg_data port; the user must write them only while
// the block is idle, since the block itself does not enforce it. One
// request is worked at a time. The average update runs on a bit-serial
// multiply-accumulate unit, one weight bit per cycle; when the average
// lies inside the early-drop band the same unit then runs a second pass to
// compare (random+1)*span against maxp*(avg-min). The next request can be
// taken in the cycle after a result is written. The result sits in an
// output register, so the next request is accepted while it waits; a
// stalled receiver holds the block only when the next result is ready to
// be written.
// Reset clears the average to zero, loads the default thresholds and
// weight, and leaves no result pending.
module red_early_drop_decider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [red_pkg::CLASS_W-1:0]   class_index,
	input  logic [red_pkg::LEN_W-1:0]     queue_length,
	input  logic [red_pkg::LEN_W-1:0]     random_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          drop,
	output logic [red_pkg::REASON_W-1:0]  drop_reason,
	output logic [red_pkg::AVG_W-1:0]     average_length,
	input  logic                          cfg_write,
	input  logic [red_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [red_pkg::CFG_W-1:0]     cfg_data
);
	import red_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EWMA = 3'd1;
	localparam logic [2:0] S_AVG  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_DEC  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]            state_q;
	logic [WEIGHT_W-1:0]   weight_q;
	logic [CFG_W-1:0]      min_thr_q;
	logic [CFG_W-1:0]      max_thr_q;
	logic [CFG_W-1:0]      max_prob_q;
	logic [AVG_W-1:0]      avg_q;
	logic [CLASS_W-1:0]    cls_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      rnd_q;
	logic [MUL_STEPS-1:0]  a_sh_q;
	logic [MUL_STEPS-1:0]  b_sh_q;
	logic [CNT_W-1:0]      cnt_q;
	op_t                   op_a_q;
	op_t                   op_b_q;
	op_t                   op_ab_q;
	logic                  early_q;
	logic                  res_drop_q;
	logic [REASON_W-1:0]   res_reason_q;
	logic                  out_valid_q;
	logic                  drop_q;
	logic [REASON_W-1:0]   reason_q;
	logic [AVG_W-1:0]      avg_out_q;

	logic [WEIGHT_W-1:0]   cfg_weight;
	logic [CLASS_W-1:0]    cls_in;
	logic                  in_fire;
	logic                  out_free;
	smac_ctl_t             ctl;
	acc_t                  acc;
	acc_t                  acc_rnd;
	logic [AVG_W-1:0]      avg_new;
	logic [5:0]            lane_lo;
	logic [LANE_W-1:0]     min16;
	logic [LANE_W-1:0]     max16;
	logic [LANE_W-1:0]     prob16;
	logic [AVG_W-1:0]      minq;
	logic [AVG_W-1:0]      maxq;
	logic                  ge_min;
	logic                  ge_max;
	logic [AVG_W-1:0]      diff;
	logic [AVG_W-1:0]      span;
	logic                  dec_drop;

	assign cfg_weight = (cfg_data[WEIGHT_W-1:0] > WEIGHT_ONE) ? WEIGHT_ONE
		: cfg_data[WEIGHT_W-1:0];
	assign cls_in = (32'(class_index) >= NUM_CLASSES) ? CLASS_W'(NUM_CLASSES - 1)
		: class_index;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign lane_lo = {cls_q, 4'd0};
	assign min16   = min_thr_q[lane_lo +: LANE_W];
	assign max16   = max_thr_q[lane_lo +: LANE_W];
	assign prob16  = max_prob_q[lane_lo +: LANE_W];
	assign minq    = {min16, 16'd0};
	assign maxq    = {max16, 16'd0};
	assign ge_min  = (avg_q >= minq);
	assign ge_max  = (avg_q >= maxq);
	assign diff    = avg_q - minq;
	assign span    = maxq - minq;

	assign acc_rnd  = acc + ACC_W'(32768);
	assign avg_new  = avg_q + acc_rnd[AVG_W+15:16];
	assign dec_drop = !acc[ACC_W-1];

	always_comb begin
		ctl.clear = in_fire || (state_q == S_CMP);
		ctl.step  = (state_q == S_EWMA) || (state_q == S_DEC);
		ctl.bit_a = a_sh_q[MUL_STEPS-1];
		ctl.bit_b = b_sh_q[MUL_STEPS-1];
	end

	red_smac u_smac (
		.clk   (clk),
		.ctl   (ctl),
		.op_a  (op_a_q),
		.op_b  (op_b_q),
		.op_ab (op_ab_q),
		.acc   (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q   <= RST_AVG_WEIGHT;
			min_thr_q  <= RST_MIN_THRESH;
			max_thr_q  <= RST_MAX_THRESH;
			max_prob_q <= RST_MAX_PROB;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_AVG_WEIGHT: weight_q   <= cfg_weight;
				REG_MIN_THRESH: min_thr_q  <= cfg_data;
				REG_MAX_THRESH: max_thr_q  <= cfg_data;
				REG_MAX_PROB:   max_prob_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			avg_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cnt_q   <= CNT_W'(MUL_STEPS);
						state_q <= S_EWMA;
					end
				end
				S_EWMA: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_AVG;
					end
				end
				S_AVG: begin
					avg_q   <= avg_new;
					state_q <= S_CMP;
				end
				S_CMP: begin
					cnt_q   <= CNT_W'(MUL_STEPS);
					state_q <= (ge_min && !ge_max) ? S_DEC : S_DONE;
				end
				S_DEC: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cls_q   <= cls_in;
					len_q   <= queue_length;
					rnd_q   <= random_value;
					a_sh_q  <= weight_q;
					b_sh_q  <= '0;
					op_a_q  <= {2'b00, queue_length, 16'd0} - {2'b00, avg_q};
					op_b_q  <= '0;
					op_ab_q <= {2'b00, queue_length, 16'd0} - {2'b00, avg_q};
				end
			end
			S_EWMA, S_DEC: begin
				a_sh_q <= {a_sh_q[MUL_STEPS-2:0], 1'b0};
				b_sh_q <= {b_sh_q[MUL_STEPS-2:0], 1'b0};
			end
			S_CMP: begin
				early_q <= ge_min && !ge_max;
				a_sh_q  <= {1'b0, prob16};
				b_sh_q  <= {1'b0, rnd_q} + MUL_STEPS'(1);
				op_a_q  <= {2'b00, diff};
				op_b_q  <= '0 - {2'b00, span};
				op_ab_q <= {2'b00, diff} - {2'b00, span};
				priority if (ge_max) begin
					res_drop_q   <= 1'b1;
					res_reason_q <= REASON_AVG_MAX;
				end else if (!ge_min && (len_q >= max16)) begin
					res_drop_q   <= 1'b1;
					res_reason_q <= REASON_LEN_MAX;
				end else begin
					res_drop_q   <= 1'b0;
					res_reason_q <= REASON_ACCEPT;
				end
			end
			S_DONE: begin
				if (out_free) begin
					avg_out_q <= avg_q;
					if (early_q) begin
						drop_q   <= dec_drop;
						reason_q <= dec_drop ? REASON_EARLY : REASON_ACCEPT;
					end else begin
						drop_q   <= res_drop_q;
						reason_q <= res_reason_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign drop           = drop_q;
	assign drop_reason    = reason_q;
	assign average_length = avg_out_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import red_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int MAX_GAP      = 14;

	typedef struct {
		logic                drop;
		logic [REASON_W-1:0] reason;
		logic [AVG_W-1:0]    avg;
	} verdict_t;

	class drop_scoreboard;
		logic [WEIGHT_W-1:0] weight;
		logic [CFG_W-1:0]    min_lanes;
		logic [CFG_W-1:0]    max_lanes;
		logic [CFG_W-1:0]    prob_lanes;
		logic [AVG_W-1:0]    avg_q;
		verdict_t            verdicts_due[$];
		int                  failures;

		function new();
			weight     = RST_AVG_WEIGHT;
			min_lanes  = RST_MIN_THRESH;
			max_lanes  = RST_MAX_THRESH;
			prob_lanes = RST_MAX_PROB;
			avg_q      = '0;
			failures   = 0;
		endfunction

		function void apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
			case (idx)
				REG_AVG_WEIGHT: begin
					weight = (value[WEIGHT_W-1:0] > WEIGHT_ONE) ? WEIGHT_ONE : value[WEIGHT_W-1:0];
				end
				REG_MIN_THRESH: min_lanes = value;
				REG_MAX_THRESH: max_lanes = value;
				REG_MAX_PROB:   prob_lanes = value;
				default: ;
			endcase
		endfunction

		function void note_request(input logic [CLASS_W-1:0] cls, input logic [LEN_W-1:0] len,
				input logic [LEN_W-1:0] rnd);
			logic [63:0] acc, lenq, minq, maxq, maxp, pb;
			verdict_t    v;
			int          lane;
			lane = LANE_W * int'(cls);
			lenq = 64'(len) << 16;
			acc  = (64'(WEIGHT_ONE) - 64'(weight)) * 64'(avg_q) + 64'(weight) * lenq + 64'd32768;
			avg_q = acc[47:16];
			minq = 64'(min_lanes[lane +: LANE_W]) << 16;
			maxq = 64'(max_lanes[lane +: LANE_W]) << 16;
			maxp = 64'(prob_lanes[lane +: LANE_W]);
			v.drop   = 1'b0;
			v.reason = REASON_ACCEPT;
			v.avg    = avg_q;
			if (minq <= 64'(avg_q) && 64'(avg_q) < maxq) begin
				pb = (maxp * (64'(avg_q) - minq)) / (maxq - minq);
				if (64'(rnd) < pb) begin
					v.drop   = 1'b1;
					v.reason = REASON_EARLY;
				end
			end else if (64'(avg_q) >= maxq) begin
				v.drop   = 1'b1;
				v.reason = REASON_AVG_MAX;
			end else if (lenq >= maxq) begin
				v.drop   = 1'b1;
				v.reason = REASON_LEN_MAX;
			end
			verdicts_due.push_back(v);
		endfunction

		function void check_result(input logic d, input logic [REASON_W-1:0] r,
				input logic [AVG_W-1:0] a);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: drop=%0b reason=%0d avg=%h", d, r, a);
				return;
			end
			want = verdicts_due.pop_front();
			if (d !== want.drop || r !== want.reason || a !== want.avg) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected drop=%0b reason=%0d avg=%h, got drop=%0b reason=%0d avg=%h",
						want.drop, want.reason, want.avg, d, r, a);
			end
		endfunction

		function int outstanding();
			return verdicts_due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CLASS_W-1:0]   class_index;
	logic [LEN_W-1:0]     queue_length;
	logic [LEN_W-1:0]     random_value;
	logic                 out_valid;
	logic                 out_ready;
	logic                 drop;
	logic [REASON_W-1:0]  drop_reason;
	logic [AVG_W-1:0]     average_length;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bit in_gaps  = 1'b1;
	bit out_gaps = 1'b1;

	drop_scoreboard book = new();

	red_early_drop_decider dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.class_index    (class_index),
		.queue_length   (queue_length),
		.random_value   (random_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drop           (drop),
		.drop_reason    (drop_reason),
		.average_length (average_length),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [LEN_W-1:0] clamp16(input int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return v[LEN_W-1:0];
	endfunction

	task automatic send_request(input logic [CLASS_W-1:0] cls, input logic [LEN_W-1:0] len,
			input logic [LEN_W-1:0] rnd);
		int gap;
		gap = in_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		class_index  <= cls;
		queue_length <= len;
		random_value <= rnd;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		book.note_request(cls, len, rnd);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (book.outstanding() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		book.apply_write(idx, value);
	endtask

	task automatic load_settings(input logic [CFG_W-1:0] wdata, input logic [CFG_W-1:0] mins,
			input logic [CFG_W-1:0] maxs, input logic [CFG_W-1:0] probs);
		put_register(REG_AVG_WEIGHT, wdata);
		put_register(REG_MIN_THRESH, mins);
		put_register(REG_MAX_THRESH, maxs);
		put_register(REG_MAX_PROB, probs);
		cfg_write <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		logic [CFG_W-1:0] wdata, mins, maxs, probs;
		logic [LEN_W-1:0] len;
		int               base, span, lo, hi, level, stride, lane;
		wait_idle();
		in_gaps  = ($urandom_range(0, 3) != 0);
		out_gaps = ($urandom_range(0, 3) != 0);
		case ($urandom_range(0, 5))
			0: wdata = CFG_W'(WEIGHT_ONE);
			1: wdata = {$urandom, $urandom};
			2: wdata = CFG_W'($urandom_range(4096, 65535));
			3: wdata = CFG_W'($urandom_range(1, 4095));
			4: wdata = '0;
			default: wdata = CFG_W'($urandom_range(16384, 65536));
		endcase
		if ($urandom_range(0, 4) == 0) begin
			base = $urandom_range(0, 65535);
			span = $urandom_range(1, 65535);
		end else begin
			base = $urandom_range(0, 300);
			span = $urandom_range(1, 200);
		end
		for (int c = 0; c < NUM_CLASSES; c++) begin
			lane = c * LANE_W;
			lo = base + $urandom_range(0, span / 2);
			case ($urandom_range(0, 7))
				0: hi = lo;
				1: hi = lo - $urandom_range(1, span);
				2: begin
					lo = 0;
					hi = base + span;
				end
				3: hi = 65535;
				default: hi = lo + $urandom_range(1, span);
			endcase
			mins[lane +: LANE_W] = clamp16(lo);
			maxs[lane +: LANE_W] = clamp16(hi);
			case ($urandom_range(0, 5))
				0: probs[lane +: LANE_W] = '0;
				1: probs[lane +: LANE_W] = '1;
				default: probs[lane +: LANE_W] = LANE_W'($urandom);
			endcase
		end
		case ($urandom_range(0, 11))
			0: begin
				mins  = '0;
				maxs  = '1;
				probs = '1;
			end
			1: begin
				mins = '1;
				maxs = '0;
			end
			default: ;
		endcase
		load_settings(wdata, mins, maxs, probs);
		level  = base + $urandom_range(0, span);
		stride = span / 8 + 1;
		repeat (count) begin
			case ($urandom_range(0, 9))
				0: len = LEN_W'($urandom);
				1: len = $urandom_range(0, 1) ? '1 : '0;
				default: begin
					level = level + $urandom_range(0, 2 * stride) - stride;
					len   = clamp16(level);
					level = int'(len);
				end
			endcase
			send_request(CLASS_W'($urandom), len, LEN_W'($urandom));
		end
	endtask

	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = out_gaps ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			book.check_result(drop, drop_reason, average_length);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int issued, count;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		class_index  <= '0;
		queue_length <= '0;
		random_value <= '0;
		cfg_write    <= 1'b0;
		cfg_index    <= REG_AVG_WEIGHT;
		cfg_data     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(2'd0, 16'd0, 16'd0);
		send_request(2'd1, 16'd49, 16'hFFFF);
		send_request(2'd2, 16'd50, 16'd0);
		send_request(2'd3, 16'hFFFF, 16'hFFFF);

		// weight field saturates to one, so the average follows the length exactly
		wait_idle();
		load_settings('1, {16'd40, 16'd30, 16'd0, 16'd10}, {16'd10, 16'd30, 16'hFFFF, 16'd20},
			{16'd0, 16'h1234, 16'h8000, 16'hFFFF});
		send_request(2'd0, 16'd9, 16'd0);
		send_request(2'd0, 16'd10, 16'd0);
		send_request(2'd0, 16'd15, 16'd0);
		send_request(2'd0, 16'd15, 16'hFFFF);
		send_request(2'd0, 16'd19, 16'd0);
		send_request(2'd0, 16'd20, 16'd0);
		send_request(2'd1, 16'd0, 16'd0);
		send_request(2'd1, 16'hFFFE, 16'd0);
		send_request(2'd1, 16'hFFFF, 16'd0);
		send_request(2'd2, 16'd29, 16'd0);
		send_request(2'd2, 16'd30, 16'd0);
		send_request(2'd3, 16'd10, 16'd0);
		send_request(2'd0, 16'd5, 16'd0);

		// freeze the average with a zero weight so classes 3 and 2 reach the hard length limit; class 1 lies in its band
		wait_idle();
		load_settings('0, {16'd40, 16'd30, 16'd0, 16'd10}, {16'd10, 16'd30, 16'hFFFF, 16'd20},
			{16'd0, 16'h1234, 16'h8000, 16'hFFFF});
		send_request(2'd3, 16'd10, 16'd0);
		send_request(2'd2, 16'd30, 16'd0);
		send_request(2'd1, 16'hFFFF, 16'd0);

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			count = $urandom_range(30, 90);
			random_phase(count);
			issued += count;
		end

		wait_idle();
		repeat (60) @(posedge clk);
		if (book.failures == 0 && book.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
